/* design/swtq_pkg.sv */
// swtq_pkg: shared types and constants of the sorted wakeup timer queue
// used by sorted_wakeup_timer_queue and its port checker
// depends on nothing
package swtq_pkg;

  localparam int unsigned IdW     = 10;
  localparam int unsigned TimeW   = 63;
  localparam int unsigned DurW    = 32;
  localparam int unsigned StatusW = 3;

  localparam logic [StatusW-1:0] StAccepted = 3'd0;
  localparam logic [StatusW-1:0] StIgnored  = 3'd1;
  localparam logic [StatusW-1:0] StRejected = 3'd2;
  localparam logic [StatusW-1:0] StNoneWoke = 3'd3;
  localparam logic [StatusW-1:0] StWoken    = 3'd4;

  localparam logic ActSleep = 1'b0;
  localparam logic ActTick  = 1'b1;

  typedef struct packed {
    logic [TimeW-1:0] wake;
    logic [IdW-1:0]   id;
  } entry_t;

endpackage

/* design/sorted_wakeup_timer_queue.sv */
// sorted_wakeup_timer_queue: tick counter and a wake-time sorted sleeper queue
// depends on swtq_pkg; the queue is a circular buffer in one memory with
// one registered read port and one write port, walked by a small sequencer
//
// Usage: one input channel (in_valid_i/in_ready_o) carries an action, a
// sleeper id and a signed sleep length; one output channel
// (out_valid_o/out_ready_i) carries the results, last_o marks the final
// result of an item. A sleep request with a positive length is inserted
// behind every entry with an equal or earlier wake time; a tick advances the
// counter and pops every due entry from the head, one result each, or gives
// a single none-woken result.
// Timing: one item at a time, ready again the cycle after its last result is
// taken. The result of an ignored or rejected request is offered in the cycle
// after acceptance. An insertion walks back from the tail, with a memory read
// and then a compare and write for each moved entry. A tick reads each entry
// from the head (memory read, then compare) and hands each wakeup result to
// the output register. Each result waits in the output register while the
// receiver stalls; the sequencer holds meanwhile.
// Reset: counter and fill clear at once, the memory is not cleared.
module sorted_wakeup_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [swtq_pkg::IdW-1:0]            sleeper_id_i,
  input  logic signed [swtq_pkg::DurW-1:0]    sleep_ticks_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [swtq_pkg::StatusW-1:0]        status_o,
  output logic [swtq_pkg::IdW-1:0]            woken_id_o,
  output logic [swtq_pkg::TimeW-1:0]          wake_time_o,
  output logic [swtq_pkg::TimeW-1:0]          tick_now_o,
  output logic                                last_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_INS_RD  = 6'b000010,
    ST_INS_CMP = 6'b000100,
    ST_POP_RD  = 6'b001000,
    ST_POP_CMP = 6'b010000,
    ST_OUT     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]                 fill_q, fill_d;
  logic [PW-1:0]                 head_q, head_d;
  logic [swtq_pkg::TimeW-1:0]    tick_q, tick_d;
  logic [CW-1:0]                 idx_q, idx_d;
  swtq_pkg::entry_t              ins_q, ins_d;
  swtq_pkg::entry_t              pend_q, pend_d;
  logic                          have_pend_q, have_pend_d;
  logic                          ret_pop_q, ret_pop_d;

  logic [swtq_pkg::StatusW-1:0]  status_q, status_d;
  logic [swtq_pkg::IdW-1:0]      woken_id_q, woken_id_d;
  logic [swtq_pkg::TimeW-1:0]    wake_time_q, wake_time_d;
  logic [swtq_pkg::TimeW-1:0]    tick_now_q, tick_now_d;
  logic                          last_q, last_d;

  swtq_pkg::entry_t              mem [QUEUE_DEPTH];
  swtq_pkg::entry_t              rd_q;
  logic                          re;
  logic [PW-1:0]                 raddr;
  logic                          we;
  logic [PW-1:0]                 waddr;
  swtq_pkg::entry_t              wdata;

  logic                          nonpos;
  logic                          due;
  logic [swtq_pkg::TimeW-1:0]    wake_new;

  function automatic logic [PW-1:0] phys(input logic [PW-1:0] head,
                                         input logic [CW-1:0] ofs);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(ofs);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CW+1)'(QUEUE_DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  assign nonpos   = sleep_ticks_i[swtq_pkg::DurW-1] || (sleep_ticks_i == '0);
  assign wake_new = tick_q + swtq_pkg::TimeW'(unsigned'(sleep_ticks_i));
  assign due      = (rd_q.wake <= tick_q);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    head_d      = head_q;
    tick_d      = tick_q;
    idx_d       = idx_q;
    ins_d       = ins_q;
    pend_d      = pend_q;
    have_pend_d = have_pend_q;
    ret_pop_d   = ret_pop_q;
    status_d    = status_q;
    woken_id_d  = woken_id_q;
    wake_time_d = wake_time_q;
    tick_now_d  = tick_now_q;
    last_d      = last_q;
    re          = 1'b0;
    raddr       = '0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = ins_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          woken_id_d  = '0;
          wake_time_d = '0;
          last_d      = 1'b1;
          ret_pop_d   = 1'b0;
          if (action_i == swtq_pkg::ActTick) begin
            tick_d      = tick_q + swtq_pkg::TimeW'(1);
            have_pend_d = 1'b0;
            state_d     = ST_POP_RD;
          end else begin
            tick_now_d = tick_q;
            if (nonpos) begin
              status_d = swtq_pkg::StIgnored;
              state_d  = ST_OUT;
            end else if (fill_q == CW'(QUEUE_DEPTH)) begin
              status_d = swtq_pkg::StRejected;
              state_d  = ST_OUT;
            end else begin
              ins_d.wake = wake_new;
              ins_d.id   = sleeper_id_i;
              idx_d      = fill_q;
              state_d    = ST_INS_RD;
            end
          end
        end
      end
      ST_INS_RD: begin
        if (idx_q == '0) begin
          we          = 1'b1;
          waddr       = phys(head_q, idx_q);
          wdata       = ins_q;
          fill_d      = fill_q + CW'(1);
          status_d    = swtq_pkg::StAccepted;
          wake_time_d = ins_q.wake;
          state_d     = ST_OUT;
        end else begin
          re      = 1'b1;
          raddr   = phys(head_q, idx_q - CW'(1));
          state_d = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        we    = 1'b1;
        waddr = phys(head_q, idx_q);
        if (rd_q.wake > ins_q.wake) begin
          wdata   = rd_q;
          idx_d   = idx_q - CW'(1);
          state_d = ST_INS_RD;
        end else begin
          wdata       = ins_q;
          fill_d      = fill_q + CW'(1);
          status_d    = swtq_pkg::StAccepted;
          wake_time_d = ins_q.wake;
          state_d     = ST_OUT;
        end
      end
      ST_POP_RD: begin
        tick_now_d = tick_q;
        if (fill_q == '0) begin
          last_d    = 1'b1;
          ret_pop_d = 1'b0;
          state_d   = ST_OUT;
          if (have_pend_q) begin
            status_d    = swtq_pkg::StWoken;
            woken_id_d  = pend_q.id;
            wake_time_d = pend_q.wake;
          end else begin
            status_d    = swtq_pkg::StNoneWoke;
            woken_id_d  = '0;
            wake_time_d = '0;
          end
        end else begin
          re      = 1'b1;
          raddr   = head_q;
          state_d = ST_POP_CMP;
        end
      end
      ST_POP_CMP: begin
        if (due) begin
          head_d      = phys(head_q, CW'(1));
          fill_d      = fill_q - CW'(1);
          pend_d      = rd_q;
          have_pend_d = 1'b1;
          if (have_pend_q) begin
            status_d    = swtq_pkg::StWoken;
            woken_id_d  = pend_q.id;
            wake_time_d = pend_q.wake;
            last_d      = 1'b0;
            ret_pop_d   = 1'b1;
            state_d     = ST_OUT;
          end else begin
            state_d = ST_POP_RD;
          end
        end else begin
          last_d    = 1'b1;
          ret_pop_d = 1'b0;
          state_d   = ST_OUT;
          if (have_pend_q) begin
            status_d    = swtq_pkg::StWoken;
            woken_id_d  = pend_q.id;
            wake_time_d = pend_q.wake;
          end else begin
            status_d    = swtq_pkg::StNoneWoke;
            woken_id_d  = '0;
            wake_time_d = '0;
          end
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ret_pop_q ? ST_POP_RD : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      head_q      <= '0;
      tick_q      <= '0;
      have_pend_q <= 1'b0;
      ret_pop_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      tick_q      <= tick_d;
      have_pend_q <= have_pend_d;
      ret_pop_q   <= ret_pop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    ins_q       <= ins_d;
    pend_q      <= pend_d;
    status_q    <= status_d;
    woken_id_q  <= woken_id_d;
    wake_time_q <= wake_time_d;
    tick_now_q  <= tick_now_d;
    last_q      <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign status_o    = status_q;
  assign woken_id_o  = woken_id_q;
  assign wake_time_o = wake_time_q;
  assign tick_now_o  = tick_now_q;
  assign last_o      = last_q;

endmodule

/* design/swtq_checker.sv */
// swtq_checker: port-level assertions for sorted_wakeup_timer_queue
// depends on swtq_pkg; attached to the top level by the bind below
module swtq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [swtq_pkg::StatusW-1:0]   status_o,
  input logic [swtq_pkg::IdW-1:0]       woken_id_o,
  input logic [swtq_pkg::TimeW-1:0]     wake_time_o,
  input logic                           last_o
);

  // no new item while a result is pending
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while a result is pending");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after an accepted item");

  // only wakeups may be followed by more results
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != swtq_pkg::StWoken) |-> (last_o && woken_id_o == '0))
    else $error("non-wakeup result not final or carries an id");

  // rejected, ignored and none-woken results carry no wake time
  a_no_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == swtq_pkg::StIgnored || status_o == swtq_pkg::StRejected
      || status_o == swtq_pkg::StNoneWoke)) |-> (wake_time_o == '0))
    else $error("wake time on a result without an entry");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_o)
      && $stable(wake_time_o) && $stable(last_o)))
    else $error("stalled result changed");

endmodule

bind sorted_wakeup_timer_queue swtq_checker u_swtq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .woken_id_o  (woken_id_o),
  .wake_time_o (wake_time_o),
  .last_o      (last_o)
);
